// ===== rtl/core/ssfc_pkg.sv =====
// shared types and constants for the sensor stream frame checker
`timescale 1ns / 1ps
`default_nettype none

package ssfc_pkg;

  localparam int unsigned WinDepth = 64;
  localparam int unsigned WinAw    = 6;
  localparam int unsigned FillW    = 7;
  localparam int unsigned ErrW     = 16;

  // one result beat as it travels from the scan engine to the output stage
  typedef struct packed {
    logic [7:0]      payload_byte;
    logic            byte_present;
    logic            frame_last;
    logic [ErrW-1:0] error_total;
  } ssfc_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/sensor_stream_frame_checker_core.sv =====
// top level: byte window memory, frame scan sequencer and configuration
//
//   port group   direction  handshake               payload
//   in           in         in_valid_i/in_stall_o    in_byte_i
//   out          out        out_valid_o/out_stall_i  payload_byte_o, byte_present_o,
//                                                    frame_last_o, error_total_o
//   cfg          in         cfg_we_i                 cfg_wdata_i (start marker)
//
// one byte is taken per scan and written to the 64-entry window; the scan then walks the
// window through its single read port: it drops junk bytes, rejects an oversize length,
// reads from the head through the checksum and emits the beats (waiting while out_stall_i
// holds) until it finds the window idle or the next frame incomplete
// in_stall_o stays high for the whole scan; a rejected frame restarts it one byte on
// reset empties the window and clears the error count; the memory itself is not cleared

`timescale 1ns / 1ps
`default_nettype none

module sensor_stream_frame_checker_core import ssfc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 61
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       payload_byte_o,
  output logic             byte_present_o,
  output logic             frame_last_o,
  output logic [ErrW-1:0]  error_total_o,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  localparam logic [8:0] MaxPay = 9'(MAX_PAYLOAD);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StHead  = 3'd1;
  localparam logic [2:0] StChk   = 3'd2;
  localparam logic [2:0] StLen   = 3'd3;
  localparam logic [2:0] StSum   = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;
  localparam logic [2:0] StEmpty = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [WinAw-1:0] head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [ErrW-1:0]  err_q, err_d;
  logic [7:0]       marker_q;
  logic [7:0]       len_q, len_d;
  logic [7:0]       sum_q, sum_d;
  logic [WinAw-1:0] idx_q, idx_d;

  logic [7:0]       mem [WinDepth];
  logic [7:0]       rdata_q;
  logic             rd_en;
  logic [WinAw-1:0] rd_addr;
  logic             wr_en;
  logic [WinAw-1:0] wr_addr;

  logic             load;
  ssfc_item_t       item;
  logic             out_free;

  logic [8:0]       frame_tot;
  logic [7:0]       sum_next;
  logic             sum_end;
  logic             emit_last;
  logic [FillW-1:0] drop_tot;

  ssfc_out_stage u_out (
    .clk_i,
    .rst_ni,
    .load_i         (load),
    .item_i         (item),
    .free_o         (out_free),
    .out_valid_o,
    .out_stall_i,
    .payload_byte_o,
    .byte_present_o,
    .frame_last_o,
    .error_total_o
  );

  function automatic logic [ErrW-1:0] err_inc(input logic [ErrW-1:0] e);
    err_inc = (e == {ErrW{1'b1}}) ? e : e + 1'b1;
  endfunction

  assign in_stall_o = (state_q != StIdle);
  assign frame_tot  = {1'b0, rdata_q} + 9'd3;
  assign sum_next   = sum_q + rdata_q;
  assign sum_end    = ({3'b0, idx_q} == ({1'b0, len_q} + 9'd2));
  assign emit_last  = ({3'b0, idx_q} == ({1'b0, len_q} + 9'd1));
  // a frame that reached the checksum fits the window, so len + 3 fits
  assign drop_tot   = FillW'(len_q) + FillW'(3);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    fill_d  = fill_q;
    err_d   = err_q;
    len_d   = len_q;
    sum_d   = sum_q;
    idx_d   = idx_q;
    rd_en   = 1'b0;
    rd_addr = head_q;
    wr_en   = 1'b0;
    wr_addr = head_q + fill_q[WinAw-1:0];
    load    = 1'b0;
    item    = '{payload_byte: rdata_q, byte_present: 1'b1, frame_last: emit_last,
                error_total: err_q};

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          wr_en = 1'b1;
          if (fill_q == FillW'(WinDepth)) begin
            // window full: oldest byte is overwritten and counted
            head_d = head_q + 1'b1;
            err_d  = err_inc(err_q);
          end else begin
            fill_d = fill_q + 1'b1;
          end
          state_d = StHead;
        end
      end
      StHead: begin
        if (fill_q == '0) begin
          state_d = StIdle;
        end else begin
          rd_en   = 1'b1;
          state_d = StChk;
        end
      end
      StChk: begin
        if (rdata_q != marker_q) begin
          // junk ahead of a start byte, read the next head right away
          head_d  = head_q + 1'b1;
          fill_d  = fill_q - 1'b1;
          err_d   = err_inc(err_q);
          rd_addr = head_q + 1'b1;
          if (fill_q == FillW'(1)) begin
            state_d = StIdle;
          end else begin
            rd_en = 1'b1;
          end
        end else if (fill_q < FillW'(2)) begin
          state_d = StIdle;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q + 1'b1;
          state_d = StLen;
        end
      end
      StLen: begin
        if ({1'b0, rdata_q} > MaxPay) begin
          head_d  = head_q + 1'b1;
          fill_d  = fill_q - 1'b1;
          err_d   = err_inc(err_q);
          state_d = StHead;
        end else if (frame_tot > {2'b0, fill_q}) begin
          state_d = StIdle;
        end else begin
          len_d   = rdata_q;
          sum_d   = marker_q + rdata_q;
          idx_d   = WinAw'(2);
          rd_en   = 1'b1;
          rd_addr = head_q + WinAw'(2);
          state_d = StSum;
        end
      end
      StSum: begin
        if (sum_end) begin
          if (sum_next != 8'd0) begin
            head_d  = head_q + 1'b1;
            fill_d  = fill_q - 1'b1;
            err_d   = err_inc(err_q);
            state_d = StHead;
          end else if (len_q == 8'd0) begin
            state_d = StEmpty;
          end else begin
            idx_d   = WinAw'(2);
            rd_en   = 1'b1;
            rd_addr = head_q + WinAw'(2);
            state_d = StEmit;
          end
        end else begin
          sum_d   = sum_next;
          idx_d   = idx_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = head_q + idx_q + 1'b1;
        end
      end
      StEmit: begin
        // read data holds while the output register is busy
        if (out_free) begin
          load = 1'b1;
          if (emit_last) begin
            head_d  = head_q + drop_tot[WinAw-1:0];
            fill_d  = fill_q - drop_tot;
            state_d = StHead;
          end else begin
            idx_d   = idx_q + 1'b1;
            rd_en   = 1'b1;
            rd_addr = head_q + idx_q + 1'b1;
          end
        end
      end
      StEmpty: begin
        item = '{payload_byte: 8'd0, byte_present: 1'b0, frame_last: 1'b1,
                 error_total: err_q};
        if (out_free) begin
          load    = 1'b1;
          head_d  = head_q + drop_tot[WinAw-1:0];
          fill_d  = fill_q - drop_tot;
          state_d = StHead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      head_q   <= '0;
      fill_q   <= '0;
      err_q    <= '0;
      marker_q <= 8'd19;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      err_q   <= err_d;
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    sum_q <= sum_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssfc_out_stage.sv =====
// output register holding one result beat until the consumer takes it
`timescale 1ns / 1ps
`default_nettype none

module ssfc_out_stage import ssfc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire ssfc_item_t         item_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              payload_byte_o,
  output logic                    byte_present_o,
  output logic                    frame_last_o,
  output logic [ErrW-1:0]         error_total_o
);

  logic       valid_q, valid_d;
  ssfc_item_t item_q;

  // the register can take a new beat when empty or when its beat leaves now
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign payload_byte_o = item_q.payload_byte;
  assign byte_present_o = item_q.byte_present;
  assign frame_last_o   = item_q.frame_last;
  assign error_total_o  = item_q.error_total;

endmodule

`default_nettype wire
